/* hdl/nec_pkg.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Shared types and constants for the NEC infrared pulse decoder.
// ----------------------------------------------------------------------------
package nec_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_EDGE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_POLL = 2'd2
  } cmd_t;

  // Configuration register indexes.
  localparam logic REG_UNIT_PERIOD = 1'b0;
  localparam logic REG_USER_CODE   = 1'b1;

  localparam int PERIOD_W = 16;
  localparam int UNIT_W   = 11;
  localparam int CODE_W   = 16;
  localparam int QUO_W    = 8;
  localparam int CNT_W    = 8;
  localparam int STEP_W   = $clog2(PERIOD_W);

  localparam logic [UNIT_W-1:0] UNIT_PERIOD_RESET = 11'd187;
  localparam logic [CODE_W-1:0] USER_CODE_RESET   = 16'hFF00;

  // Decoding thresholds, in units or in timeout ticks.
  localparam logic [QUO_W-1:0] Q_ONE        = 8'd2;
  localparam logic [QUO_W-1:0] Q_SYNC       = 8'd13;
  localparam logic [QUO_W-1:0] Q_SHORT      = 8'd8;
  localparam logic [QUO_W-1:0] Q_LONG       = 8'd20;
  localparam logic [CNT_W-1:0] T_SYNC       = 8'd8;
  localparam logic [CNT_W-1:0] T_SHORT      = 8'd5;
  localparam logic [CNT_W-1:0] T_IDLE       = 8'd53;
  localparam logic [CNT_W-1:0] T_TIMEOUT    = 8'd56;
  localparam logic [CNT_W-1:0] BITS_USER    = 8'd16;
  localparam logic [CNT_W-1:0] BITS_FRAME   = 8'd32;
  localparam logic [7:0]       CHECK_XOR    = 8'hFF;
  localparam logic [7:0]       KEY_OFFSET   = 8'h20;
  localparam logic [7:0]       NO_KEY       = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_COMMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_edge;
    logic div_last;
  } sts_t;

endpackage

/* hdl/nec_ifs.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder channels
// Valid/ready channels for incoming requests and outgoing results.
// ----------------------------------------------------------------------------
interface nec_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] edge_period;

  modport source (output valid, command, edge_period, input ready);
  modport sink   (input valid, command, edge_period, output ready);
endinterface

interface nec_out_if;
  logic       valid;
  logic       ready;
  logic       key_valid;
  logic [7:0] key_index;
  logic [7:0] frame_bits;

  modport source (output valid, key_valid, key_index, frame_bits, input ready);
  modport sink   (input valid, key_valid, key_index, frame_bits, output ready);
endinterface

/* hdl/nec_ctrl.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder controller
// Sequences request intake, the serial divide and the result commit.
// ----------------------------------------------------------------------------
module nec_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  nec_pkg::sts_t sts,
  output nec_pkg::ctl_t ctl
);

  nec_pkg::state_t state;
  nec_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nec_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.in_edge ? nec_pkg::ST_DIVIDE : nec_pkg::ST_COMMIT;
        end
      end
      nec_pkg::ST_DIVIDE: begin
        if (sts.div_last) begin
          state_next = nec_pkg::ST_COMMIT;
        end
      end
      nec_pkg::ST_COMMIT: begin
        if (out_free) begin
          state_next = nec_pkg::ST_IDLE;
        end
      end
      default: state_next = nec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl.load   = 1'b0;
    ctl.step   = 1'b0;
    ctl.commit = 1'b0;
    unique case (state)
      nec_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      nec_pkg::ST_DIVIDE: begin
        ctl.step = 1'b1;
      end
      nec_pkg::ST_COMMIT: begin
        ctl.commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // The result register is full from a commit until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/nec_datapath.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder datapath
// Serial divider, frame state registers, configuration and result register.
// ----------------------------------------------------------------------------
module nec_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [nec_pkg::CODE_W-1:0]    wr_data,
  input  logic [1:0]                    command,
  input  logic [nec_pkg::PERIOD_W-1:0]  edge_period,
  input  nec_pkg::ctl_t                 ctl,
  output nec_pkg::sts_t                 sts,
  output logic                          key_valid,
  output logic [7:0]                    key_index,
  output logic [nec_pkg::CNT_W-1:0]     frame_bits
);

  logic [nec_pkg::UNIT_W-1:0]   unit_period;
  logic [nec_pkg::CODE_W-1:0]   expected_user_code;

  logic [1:0]                   cmd;
  logic [nec_pkg::PERIOD_W-1:0] dividend;
  logic [nec_pkg::UNIT_W-1:0]   rem;
  logic [nec_pkg::QUO_W-1:0]    quo;
  logic [nec_pkg::STEP_W-1:0]   step_cnt;

  logic [nec_pkg::CODE_W-1:0]   shift_data;
  logic [nec_pkg::CNT_W-1:0]    bit_count;
  logic [nec_pkg::CNT_W-1:0]    tick_count;
  logic [nec_pkg::CODE_W-1:0]   user_code;

  logic [nec_pkg::CODE_W-1:0]   shift_data_next;
  logic [nec_pkg::CNT_W-1:0]    bit_count_next;
  logic [nec_pkg::CNT_W-1:0]    tick_count_next;
  logic [nec_pkg::CODE_W-1:0]   user_code_next;
  logic                         key_valid_next;
  logic [7:0]                   key_index_next;

  logic [nec_pkg::UNIT_W:0]     trial;
  logic [nec_pkg::UNIT_W:0]     diff;
  logic                         fits;
  logic [7:0]                   lo;
  logic [7:0]                   hi;

  assign sts.in_edge  = (command == nec_pkg::CMD_EDGE);
  assign sts.div_last = (step_cnt == nec_pkg::STEP_W'(nec_pkg::PERIOD_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_period        <= nec_pkg::UNIT_PERIOD_RESET;
      expected_user_code <= nec_pkg::USER_CODE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        nec_pkg::REG_UNIT_PERIOD: unit_period <= wr_data[nec_pkg::UNIT_W-1:0];
        nec_pkg::REG_USER_CODE:   expected_user_code <= wr_data;
        default: unit_period <= unit_period;
      endcase
    end
  end

  // Restoring division, one quotient bit a cycle. A zero divisor always fits,
  // which yields an all-ones quotient.
  assign trial = {rem, dividend[nec_pkg::PERIOD_W-1]};
  assign fits  = (trial >= {1'b0, unit_period});
  assign diff  = trial - {1'b0, unit_period};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd      <= command;
      dividend <= edge_period;
      rem      <= '0;
      quo      <= '0;
      step_cnt <= '0;
    end else if (ctl.step) begin
      dividend <= {dividend[nec_pkg::PERIOD_W-2:0], 1'b0};
      rem      <= fits ? diff[nec_pkg::UNIT_W-1:0] : trial[nec_pkg::UNIT_W-1:0];
      quo      <= {quo[nec_pkg::QUO_W-2:0], fits};
      step_cnt <= step_cnt + 1'b1;
    end
  end

  assign lo = shift_data[7:0];
  assign hi = shift_data[15:8];

  always_comb begin
    shift_data_next = shift_data;
    bit_count_next  = bit_count;
    tick_count_next = tick_count;
    user_code_next  = user_code;
    key_valid_next  = 1'b0;
    key_index_next  = nec_pkg::NO_KEY;
    case (cmd)
      nec_pkg::CMD_EDGE: begin
        if (quo <= nec_pkg::Q_ONE) begin
          shift_data_next = {(quo == nec_pkg::Q_ONE), shift_data[15:1]};
          bit_count_next  = bit_count + 1'b1;
          tick_count_next = '0;
        end else if (quo == nec_pkg::Q_SYNC && tick_count < nec_pkg::T_SYNC) begin
          bit_count_next = '0;
        end else if (quo < nec_pkg::Q_SHORT && tick_count < nec_pkg::T_SHORT) begin
          bit_count_next = '0;
        end else if (quo > nec_pkg::Q_LONG && tick_count > nec_pkg::T_IDLE) begin
          bit_count_next = '0;
        end else begin
          tick_count_next = '0;
        end
        if (bit_count_next == nec_pkg::BITS_USER) begin
          user_code_next = shift_data_next;
        end
      end
      nec_pkg::CMD_TICK: begin
        tick_count_next = tick_count + 1'b1;
        if (tick_count_next > nec_pkg::T_TIMEOUT) begin
          bit_count_next = '0;
        end
      end
      nec_pkg::CMD_POLL: begin
        if (bit_count == nec_pkg::BITS_FRAME) begin
          if ((lo ^ hi) != nec_pkg::CHECK_XOR) begin
            bit_count_next = '0;
          end else if (user_code == expected_user_code) begin
            key_valid_next = 1'b1;
            key_index_next = (lo > nec_pkg::KEY_OFFSET) ? lo - nec_pkg::KEY_OFFSET : lo;
          end
        end
      end
      default: begin
        key_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_data <= '0;
      bit_count  <= '0;
      tick_count <= '0;
      user_code  <= '0;
    end else if (ctl.commit) begin
      shift_data <= shift_data_next;
      bit_count  <= bit_count_next;
      tick_count <= tick_count_next;
      user_code  <= user_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      key_valid  <= key_valid_next;
      key_index  <= key_index_next;
      frame_bits <= bit_count_next;
    end
  end

endmodule

/* hdl/nec_ir_pulse_decoder.sv */
// An edge request is taken in the idle state, runs through the divider at
// one quotient bit per cycle and then commits; tick and poll requests go
// from idle straight to the commit. A commit waits while the result register
// holds an untaken result, and no new request is taken until the last one
// has committed. Synchronous active-high reset clears the frame state and
// loads unit_period 187 and expected_user_code 0xFF00.
// ----------------------------------------------------------------------------
// NEC IR pulse decoder
// Decodes an NEC-style infrared frame from captured edge-to-edge periods.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic                       wr_index,
  input  logic [nec_pkg::CODE_W-1:0] wr_data,
  nec_in_if.sink                     req,
  nec_out_if.source                  rsp
);

  // The controller owns the handshakes and the sequencing: a request is taken
  // in the idle state, an edge request spends one cycle per quotient bit in
  // the divider, and every request ends with a commit that updates the frame
  // state and loads the result register. A commit waits while the result
  // register still holds an untaken result, so no result is ever lost.
  nec_pkg::ctl_t ctl;
  nec_pkg::sts_t sts;

  nec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // The datapath quantizes the period by unit_period, applies the bit, sync,
  // idle and timeout rules, and checks a complete frame when polled. Key
  // codes above 0x20 have that offset removed.
  nec_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .command     (req.command),
    .edge_period (req.edge_period),
    .ctl         (ctl),
    .sts         (sts),
    .key_valid   (rsp.key_valid),
    .key_index   (rsp.key_index),
    .frame_bits  (rsp.frame_bits)
  );

endmodule
